/* sv/stack_arithmetic_unit_assert.svh */
// Assertion macros for the stack arithmetic unit.
`ifndef STACK_ARITHMETIC_UNIT_ASSERT_SVH
`define STACK_ARITHMETIC_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Checks that a condition holds at every rising clock edge outside reset.
`define SAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition in one cycle implies another in the next.
`define SAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SAU_ASSERT(lbl, prop, msg)
`define SAU_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* sv/sau_pkg.sv */
// Shared types and constants of the stack arithmetic unit.
`default_nettype none

package sau_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned OP_W        = 3;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned DEPTH_W     = 9;
  localparam int unsigned OUT_TDATA_W = 48;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_MOD  = 3'd5
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_SHORT   = 2'd1,
    ST_DIVZERO = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_OPER,
    S_DIV,
    S_DONE
  } state_e;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quot;
    logic [DATA_W-1:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

/* sv/stack_arithmetic_unit.sv */
// Stack arithmetic unit: one instruction word in, one status word out per instruction.
// The unit keeps a stack of signed 32-bit integers. The top entry lives in a register and
// the entries below it in a synchronous RAM, so every binary operation reads one RAM entry
// (the second operand) and writes nothing back: the result becomes the new top. Push,
// failing instructions and unused opcodes skip the operate state; div and mod also wait
// on the shared divider, which produces one quotient bit per cycle. A finished word waits
// in the output register while the next instruction is taken. Errors (stack too short,
// zero divisor, stack full) leave the stack unchanged. Each output word reports the top
// entry (zero when empty) and the entry count.
`default_nettype none

module stack_arithmetic_unit #(
  parameter int unsigned STACK_DEPTH = 256
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [sau_pkg::DATA_W-1:0]        s_axis_tdata,  // [31:0] push_value
  input  wire logic [sau_pkg::OP_W-1:0]          s_axis_tuser,  // [2:0] opcode
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic      [sau_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // [31:0] top_value,
                                                                // [40:32] stack_depth
  output logic      [sau_pkg::STATUS_W-1:0]      m_axis_tuser   // [1:0] status
);

  import sau_pkg::*;

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  state_e            state_q, state_d;
  logic [OP_W-1:0]   op_q, op_d;
  status_e           status_q, status_d;
  logic              pop_q, pop_d;
  logic [DATA_W-1:0] res_q, res_d;
  logic [DATA_W-1:0] top_q, top_d;
  logic [CW-1:0]     count_q, count_d;
  logic              m_valid_q, m_valid_d;
  logic [OUT_TDATA_W-1:0] m_tdata_q, m_tdata_d;
  logic [STATUS_W-1:0]    m_tuser_q, m_tuser_d;

  logic              accept;
  logic              out_free;
  logic              in_arith;
  logic              in_divide;
  logic              op_divide;
  logic              stack_short;
  logic              stack_full;
  logic [CW-1:0]     cnt_m1;
  logic [CW-1:0]     cnt_m2;
  logic [CW-1:0]     nxt_count;
  logic [DATA_W-1:0] nxt_top;
  logic [DATA_W-1:0] product;

  logic              ram_we;
  logic              ram_re;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] ram_rdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  assign in_arith    = (s_axis_tuser >= OP_ADD) && (s_axis_tuser <= OP_MOD);
  assign in_divide   = (s_axis_tuser == OP_DIV) || (s_axis_tuser == OP_MOD);
  assign op_divide   = (op_q == OP_DIV) || (op_q == OP_MOD);
  assign stack_short = (count_q < CW'(2));
  assign stack_full  = (count_q == CW'(STACK_DEPTH));

  assign cnt_m1 = count_q - CW'(1);
  assign cnt_m2 = count_q - CW'(2);

  assign product = ram_rdata * top_q;

  assign nxt_count = pop_q ? cnt_m1 : count_q;
  assign nxt_top   = pop_q ? res_q : top_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_arith && !stack_short && !(in_divide && (top_q == '0))) begin
            state_d = S_OPER;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_OPER: begin
        state_d = op_divide ? S_DIV : S_DONE;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    op_d      = op_q;
    status_d  = status_q;
    pop_d     = pop_q;
    res_d     = res_q;
    top_d     = top_q;
    count_d   = count_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_tdata_d = m_tdata_q;
    m_tuser_d = m_tuser_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = cnt_m1[AW-1:0];
    ram_raddr = cnt_m2[AW-1:0];
    ram_wdata = top_q;
    div_req   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d     = s_axis_tuser;
          status_d = ST_OK;
          pop_d    = 1'b0;
          if (s_axis_tuser == OP_PUSH) begin
            if (stack_full) begin
              status_d = ST_FULL;
            end else begin
              // The old top moves down into the RAM.
              ram_we  = (count_q != '0);
              top_d   = s_axis_tdata;
              count_d = count_q + CW'(1);
            end
          end else if (in_arith) begin
            if (stack_short) begin
              status_d = ST_SHORT;
            end else if (in_divide && (top_q == '0)) begin
              status_d = ST_DIVZERO;
            end else begin
              ram_re = 1'b1;
              pop_d  = 1'b1;
            end
          end
        end
      end
      S_OPER: begin
        case (op_q)
          OP_ADD:  res_d = ram_rdata + top_q;
          OP_SUB:  res_d = ram_rdata - top_q;
          OP_MUL:  res_d = product;
          default: begin
            div_req.start    = 1'b1;
            div_req.dividend = ram_rdata;
            div_req.divisor  = top_q;
          end
        endcase
      end
      S_DIV: begin
        if (div_rsp.done) begin
          res_d = (op_q == OP_DIV) ? div_rsp.quot : div_rsp.rem;
        end
      end
      S_DONE: begin
        if (out_free) begin
          top_d     = nxt_top;
          count_d   = nxt_count;
          m_valid_d = 1'b1;
          m_tuser_d = status_q;
          m_tdata_d = '0;
          m_tdata_d[DATA_W-1:0] = (nxt_count != '0) ? nxt_top : '0;
          m_tdata_d[DATA_W +: DEPTH_W] = DEPTH_W'(nxt_count);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    status_q  <= status_d;
    pop_q     <= pop_d;
    res_q     <= res_d;
    top_q     <= top_d;
    m_tdata_q <= m_tdata_d;
    m_tuser_q <= m_tuser_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tuser  = m_tuser_q;

  sau_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sau_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

`include "stack_arithmetic_unit_assert.svh"

  `SAU_ASSERT(a_count_bound, count_q <= CW'(STACK_DEPTH), "entry count above stack depth")
  `SAU_ASSERT(a_count_step, count_q - $past(count_q) + CW'(1) <= CW'(2),
              "entry count moved by more than one")
  `SAU_ASSERT(a_div_done_state, !div_rsp.done || (state_q == S_DIV),
              "divider finished outside divide wait")
  `SAU_ASSERT_NEXT(a_full_push, accept && (s_axis_tuser == OP_PUSH) && stack_full,
                   $stable(count_q), "push on a full stack changed the count")

endmodule

`default_nettype wire

/* sv/sau_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module sau_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* sv/sau_div.sv */
// Iterative signed divider: one quotient bit per cycle on the magnitudes.
`default_nettype none

module sau_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sau_pkg::div_req_t req_i,
  output sau_pkg::div_rsp_t      rsp_o
);

  import sau_pkg::*;

  localparam int unsigned CNT_W = $clog2(DATA_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DATA_W-1:0] quo_q, quo_d;
  logic [DATA_W-1:0] dvs_q, dvs_d;
  logic              qneg_q, qneg_d;
  logic              rneg_q, rneg_d;
  logic [DATA_W:0]   trial;

  assign trial = {rem_q, quo_q[DATA_W-1]} - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    qneg_d = qneg_q;
    rneg_d = rneg_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend[DATA_W-1] ? (DATA_W'(0) - req_i.dividend) : req_i.dividend;
      dvs_d  = req_i.divisor[DATA_W-1] ? (DATA_W'(0) - req_i.divisor) : req_i.divisor;
      qneg_d = req_i.dividend[DATA_W-1] ^ req_i.divisor[DATA_W-1];
      rneg_d = req_i.dividend[DATA_W-1];
    end else if (busy_q) begin
      // Restoring step: keep the trial difference only when it did not go negative.
      if (!trial[DATA_W]) begin
        rem_d = trial[DATA_W-1:0];
        quo_d = {quo_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DATA_W-2:0], quo_q[DATA_W-1]};
        quo_d = {quo_q[DATA_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DATA_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    dvs_q  <= dvs_d;
    qneg_q <= qneg_d;
    rneg_q <= rneg_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = qneg_q ? (DATA_W'(0) - quo_q) : quo_q;
  assign rsp_o.rem  = rneg_q ? (DATA_W'(0) - rem_q) : rem_q;

endmodule

`default_nettype wire

/* tb/tb_stack_arithmetic_unit.sv */
// Self-checking testbench for the stack arithmetic unit, with scoreboard and stream drivers.
`timescale 1ns / 100ps

module tb_stack_arithmetic_unit;
  import sau_pkg::*;

  localparam int unsigned STACK_DEPTH = 256;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned SETTLE      = 80;

  // Opcodes 6 and 7 have no enum member; the unit answers them with status OK and leaves the stack unchanged.
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  localparam logic [DATA_W-1:0] WORD_MAX  = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] WORD_MIN  = 32'h8000_0000;
  localparam logic [DATA_W-1:0] WORD_ONES = 32'hFFFF_FFFF;

  typedef struct {
    status_e            status;
    logic [DATA_W-1:0]  top;
    logic [DEPTH_W-1:0] depth;
  } stack_word_t;

  class stack_scoreboard;
    logic [DATA_W-1:0] store [STACK_DEPTH];
    int unsigned       count;
    stack_word_t       expected_q[$];
    int unsigned       errors;

    function new();
      count  = 0;
      errors = 0;
    endfunction

    function int unsigned depth();
      return count;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function logic [DATA_W-1:0] magnitude(logic [DATA_W-1:0] v);
      return v[DATA_W-1] ? (32'd0 - v) : v;
    endfunction

    // Truncating division on two's complement patterns; the quotient of the most
    // negative value by minus one wraps back to the most negative value.
    function logic [DATA_W-1:0] quotient(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
      logic [DATA_W-1:0] q;
      q = magnitude(a) / magnitude(b);
      if (a[DATA_W-1] ^ b[DATA_W-1]) q = 32'd0 - q;
      return q;
    endfunction

    function logic [DATA_W-1:0] remainder(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
      logic [DATA_W-1:0] r;
      r = magnitude(a) % magnitude(b);
      if (a[DATA_W-1]) r = 32'd0 - r;
      return r;
    endfunction

    function void note_instruction(logic [OP_W-1:0] op, logic [DATA_W-1:0] val);
      stack_word_t       w;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
      logic [DATA_W-1:0] res;
      bit                ok;
      w.status = ST_OK;
      if (op == OP_PUSH) begin
        if (count >= STACK_DEPTH) begin
          w.status = ST_FULL;
        end else begin
          store[count] = val;
          count++;
        end
      end else if (op <= OP_MOD) begin
        if (count < 2) begin
          w.status = ST_SHORT;
        end else begin
          b   = store[count-1];
          a   = store[count-2];
          res = '0;
          ok  = 1'b1;
          case (op)
            OP_ADD: res = a + b;
            OP_SUB: res = a - b;
            OP_MUL: res = a * b;
            OP_DIV: begin
              if (b == 0) ok = 1'b0;
              else res = quotient(a, b);
            end
            default: begin
              if (b == 0) ok = 1'b0;
              else res = remainder(a, b);
            end
          endcase
          if (ok) begin
            store[count-2] = res;
            count--;
          end else begin
            w.status = ST_DIVZERO;
          end
        end
      end
      w.top   = (count > 0) ? store[count-1] : '0;
      w.depth = count[DEPTH_W-1:0];
      expected_q.push_back(w);
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [OUT_TDATA_W-1:0] tdata);
      stack_word_t exp_w;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word, status %0d top %h depth %0d",
                 $time, status, tdata[31:0], tdata[40:32]);
        errors++;
        return;
      end
      exp_w = expected_q.pop_front();
      if (status !== exp_w.status) begin
        $display("%0t: status mismatch, expected %0d actual %0d", $time, exp_w.status, status);
        errors++;
      end
      if (tdata[31:0] !== exp_w.top) begin
        $display("%0t: top mismatch, expected %h actual %h", $time, exp_w.top, tdata[31:0]);
        errors++;
      end
      if (tdata[40:32] !== exp_w.depth) begin
        $display("%0t: depth mismatch, expected %0d actual %0d",
                 $time, exp_w.depth, tdata[40:32]);
        errors++;
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [DATA_W-1:0]      s_axis_tdata = '0;
  logic [OP_W-1:0]        s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]    m_axis_tuser;

  stack_scoreboard sb = new();
  int unsigned     cycles = 0;
  bit              tx_quiet = 1'b0;
  bit              rx_quiet = 1'b0;
  bit              hold_req = 1'b0;

  always #4 clk_i = ~clk_i;

  stack_arithmetic_unit #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: random stalls, quiet stretches, and one long hold-off on request.
  // Handshake signals are sampled at the falling edge, where they are settled.
  initial begin
    int unsigned            stall;
    bit                     seen;
    logic [STATUS_W-1:0]    got_user;
    logic [OUT_TDATA_W-1:0] got_data;
    @(posedge rst_ni);
    forever begin
      stall = rx_quiet ? 0 : $urandom_range(0, 15);
      if (hold_req) begin
        stall    = LONG_HOLD;
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do begin
        @(negedge clk_i);
        seen     = m_axis_tvalid;
        got_user = m_axis_tuser;
        got_data = m_axis_tdata;
        @(posedge clk_i);
      end while (!seen);
      sb.check_result(got_user, got_data);
    end
  end

  // Keeps tvalid high straight into the next word when no gap is drawn.
  task automatic send_word(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val);
    int unsigned gap;
    bit          ready_seen;
    gap = tx_quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= val;
    s_axis_tuser  <= op;
    do begin
      @(negedge clk_i);
      ready_seen = s_axis_tready;
      @(posedge clk_i);
    end while (!ready_seen);
    sb.note_instruction(op, val);
  endtask

  task automatic push_word(input logic [DATA_W-1:0] val);
    send_word(OP_PUSH, val);
  endtask

  task automatic do_op(input logic [OP_W-1:0] op);
    send_word(op, $urandom());
  endtask

  // Drops tvalid and waits until every expected word has come.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return $urandom_range(0, 16) - 8;
      2: begin
        case ($urandom_range(0, 3))
          0: return WORD_MAX;
          1: return WORD_MIN;
          2: return WORD_ONES;
          default: return 32'd1;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_arith();
    return OP_W'(OP_ADD + $urandom_range(0, 4));
  endfunction

  initial begin
    int unsigned accepted;
    int unsigned npush;
    int unsigned nops;
    logic [OP_W-1:0] op;
    bit          hold_done;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: short stack, wrap on add, quotient overflow, zero divisor,
    // spare opcodes, signed remainder and wrapping product.
    do_op(OP_ADD);
    do_op(OP_DIV);
    push_word(WORD_MAX);
    do_op(OP_MOD);
    push_word(32'd1);
    do_op(OP_ADD);
    push_word(WORD_ONES);
    do_op(OP_DIV);
    push_word(WORD_ONES);
    do_op(OP_MOD);
    push_word('0);
    do_op(OP_DIV);
    do_op(OP_MOD);
    send_word(OP_SPARE_LO, WORD_ONES);
    send_word(OP_SPARE_HI, '0);
    push_word(-32'sd7);
    push_word(32'd2);
    do_op(OP_MOD);
    push_word(32'd2);
    do_op(OP_SUB);
    push_word(WORD_MIN);
    do_op(OP_MUL);
    push_word(WORD_MAX);
    do_op(OP_MUL);
    push_word(-32'sd3);
    do_op(OP_DIV);
    wait_drained();

    // Random: mostly push runs followed by arithmetic, with some loose noise.
    accepted  = 0;
    hold_done = 1'b0;
    while (accepted < 220) begin
      tx_quiet = ($urandom_range(0, 4) == 0);
      rx_quiet = ($urandom_range(0, 4) == 0);
      if (!hold_done && accepted > 100) begin
        // Hold results back while words keep coming, so the input stalls.
        hold_req = 1'b1;
        tx_quiet = 1'b1;
        repeat (12) begin
          push_word(pick_value());
          accepted++;
        end
        hold_done = 1'b1;
      end else if ($urandom_range(0, 6) == 0) begin
        op = OP_W'($urandom_range(0, 7));
        send_word(op, pick_value());
        if (op <= OP_MOD) accepted++;
      end else begin
        npush = $urandom_range(1, 4);
        nops  = (sb.depth() > 24) ? npush + 2 : $urandom_range(0, npush + 1);
        repeat (npush) push_word(pick_value());
        repeat (nops) do_op(pick_arith());
        accepted += npush + nops;
      end
      if ($urandom_range(0, 40) == 0) wait_drained();
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    wait_drained();

    // Fill the stack, overflow it, then work at the top.
    while (sb.depth() < STACK_DEPTH) push_word(pick_value());
    repeat (3) push_word(pick_value());
    send_word(OP_SPARE_HI, pick_value());
    do_op(OP_ADD);
    do_op(OP_DIV);
    do_op(OP_MOD);
    push_word(pick_value());
    push_word(pick_value());
    push_word(pick_value());

    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/sau_pkg.sv
sv/sau_ram.sv
sv/sau_div.sv
sv/stack_arithmetic_unit.sv
tb/tb_stack_arithmetic_unit.sv
